/* src/utf8vt_pkg.sv */
`timescale 1ns / 1ps

package utf8vt_pkg;

  // Default width of the string byte counter.
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Width of the limit register and of the reported safe length.
  localparam int unsigned LEN_WIDTH = 16;

  // Byte range limits used by the decoder.
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD3_SURR = 8'hED;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_MAX   = 8'hBF;
  localparam logic [7:0] CONT_HI_A0 = 8'hA0;
  localparam logic [7:0] CONT_LO_9F = 8'h9F;
  localparam logic [7:0] CONT_HI_90 = 8'h90;
  localparam logic [7:0] CONT_LO_8F = 8'h8F;

  // Reset value of the truncation limit.
  localparam logic [LEN_WIDTH-1:0] LIMIT_RESET = 16'd2000;

  // Allowed range for the next continuation byte.
  typedef enum logic [2:0] {
    CLS_ANY   = 3'd0,
    CLS_A0_BF = 3'd1,
    CLS_80_9F = 3'd2,
    CLS_90_BF = 3'd3,
    CLS_80_8F = 3'd4
  } cont_class_t;

  // Decoder verdict for one byte.
  typedef struct packed {
    logic        done;
    logic        err;
    logic [1:0]  pending;
    cont_class_t cls;
  } dec_result_t;

endpackage

/* src/utf8vt_decode.sv */
`timescale 1ns / 1ps

module utf8vt_decode (
  input  logic [7:0]                data_byte,
  input  logic [1:0]                pending_count,
  input  utf8vt_pkg::cont_class_t   second_class,
  input  logic                      error_flag,
  output utf8vt_pkg::dec_result_t   result
);
  import utf8vt_pkg::*;

  logic cont_ok;

  // Range check of a continuation byte against the expected class.
  always_comb begin
    unique case (second_class)
      CLS_A0_BF: cont_ok = (data_byte >= CONT_HI_A0) && (data_byte <= CONT_MAX);
      CLS_80_9F: cont_ok = (data_byte >= CONT_MIN) && (data_byte <= CONT_LO_9F);
      CLS_90_BF: cont_ok = (data_byte >= CONT_HI_90) && (data_byte <= CONT_MAX);
      CLS_80_8F: cont_ok = (data_byte >= CONT_MIN) && (data_byte <= CONT_LO_8F);
      default:   cont_ok = (data_byte & CONT_MASK) == CONT_TAG;
    endcase
  end

  // Sequence state update. Once an error is seen decoding stops.
  always_comb begin
    result.done    = 1'b0;
    result.err     = error_flag;
    result.pending = pending_count;
    result.cls     = second_class;
    priority if (error_flag) begin
      result.done = 1'b0;
    end else if (pending_count != 2'd0) begin
      if (cont_ok) begin
        result.cls     = CLS_ANY;
        result.pending = pending_count - 2'd1;
        result.done    = (pending_count == 2'd1);
      end else begin
        result.err = 1'b1;
      end
    end else if (data_byte <= ASCII_MAX) begin
      result.done = 1'b1;
    end else if ((data_byte >= LEAD2_MIN) && (data_byte <= LEAD2_MAX)) begin
      result.pending = 2'd1;
      result.cls     = CLS_ANY;
    end else if ((data_byte >= LEAD3_MIN) && (data_byte <= LEAD3_MAX)) begin
      result.pending = 2'd2;
      result.cls     = (data_byte == LEAD3_MIN)  ? CLS_A0_BF :
                       (data_byte == LEAD3_SURR) ? CLS_80_9F : CLS_ANY;
    end else if ((data_byte >= LEAD4_MIN) && (data_byte <= LEAD4_MAX)) begin
      result.pending = 2'd3;
      result.cls     = (data_byte == LEAD4_MIN) ? CLS_90_BF :
                       (data_byte == LEAD4_MAX) ? CLS_80_8F : CLS_ANY;
    end else begin
      result.err = 1'b1;
    end
  end

endmodule

/* src/utf8_validate_truncate_unit.sv */
`timescale 1ns / 1ps

// Streaming strict UTF-8 checker with safe truncation length. One byte item
// is accepted every clock cycle when the output side is not stalled; each
// item gives one result item by way of the input register, then the decode
// and count update into the result register. The rate of one byte per
// cycle is set by the combinational decode and saturating byte counter
// that run between the two registers. Each result carries char_done and the
// sticky invalid_seen flag; on the item marked last_byte it also carries
// string_valid and safe_length, after which the string state is cleared for
// the next string. byte_limit may be written only while no item is in flight.
module utf8_validate_truncate_unit #(
  parameter int unsigned COUNT_WIDTH = utf8vt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              last_byte,
  // Configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [utf8vt_pkg::LEN_WIDTH-1:0]  byte_limit,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              char_done,
  output logic                              invalid_seen,
  output logic                              is_last,
  output logic                              string_valid,
  output logic [utf8vt_pkg::LEN_WIDTH-1:0]  safe_length
);
  import utf8vt_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = {COUNT_WIDTH{1'b1}};
  localparam logic [31:0]            LEN_CAP   = 32'((64'd1 << LEN_WIDTH) - 64'd1);

  // Configuration register
  logic [LEN_WIDTH-1:0]   limit;

  // Input register stage
  logic                   a_valid;
  logic [7:0]             a_byte;
  logic                   a_last;

  // String state
  logic [COUNT_WIDTH-1:0] byte_count;
  logic [1:0]             pending_count;
  cont_class_t            second_class;
  logic                   error_flag;
  logic [COUNT_WIDTH-1:0] prefix_end;

  // Combinational next values
  dec_result_t            dec;
  logic [COUNT_WIDTH-1:0] byte_count_next;
  logic [COUNT_WIDTH-1:0] prefix_end_next;
  logic                   within_limit;
  logic [31:0]            safe_wide;
  logic [LEN_WIDTH-1:0]   safe_next;
  logic                   valid_next;
  logic                   b_load;
  logic                   a_load;

  // Handshake: the result register frees when empty or taken.
  assign b_load    = !out_valid || !out_stall;
  assign a_load    = !a_valid || b_load;
  assign in_stall  = !a_load;
  assign cfg_ready = 1'b1;

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= byte_limit;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && in_valid) begin
      a_byte <= data_byte;
      a_last <= last_byte;
    end
  end

  utf8vt_decode u_decode (
    .data_byte     (a_byte),
    .pending_count (pending_count),
    .second_class  (second_class),
    .error_flag    (error_flag),
    .result        (dec)
  );

  // Byte count, limit check and safe prefix.
  always_comb begin
    byte_count_next = (byte_count == COUNT_SAT) ? byte_count
                                                : byte_count + 1'b1;
    within_limit    = 32'(byte_count_next) <= 32'(limit);
    prefix_end_next = (!error_flag && dec.done && within_limit) ? byte_count_next
                                                                : prefix_end;
    safe_wide       = within_limit ? 32'(byte_count_next) : 32'(prefix_end_next);
    safe_next       = (safe_wide > LEN_CAP) ? LEN_CAP[LEN_WIDTH-1:0]
                                            : safe_wide[LEN_WIDTH-1:0];
    valid_next      = !dec.err && (dec.pending == 2'd0);
  end

  // String state, cleared after the last byte of each string.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      pending_count <= 2'd0;
      second_class  <= CLS_ANY;
      error_flag    <= 1'b0;
      prefix_end    <= '0;
    end else if (a_valid && b_load) begin
      if (a_last) begin
        byte_count    <= '0;
        pending_count <= 2'd0;
        second_class  <= CLS_ANY;
        error_flag    <= 1'b0;
        prefix_end    <= '0;
      end else begin
        byte_count    <= byte_count_next;
        pending_count <= dec.pending;
        second_class  <= dec.cls;
        error_flag    <= dec.err;
        prefix_end    <= prefix_end_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_load) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid) begin
      char_done    <= dec.done;
      invalid_seen <= dec.err;
      is_last      <= a_last;
      string_valid <= a_last && valid_next;
      safe_length  <= a_last ? safe_next : '0;
    end
  end

`ifndef SYNTH
  // A completed character never coincides with a recorded error.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && char_done |-> !invalid_seen)
    else $error("char_done reported together with invalid_seen");

  // A valid string has seen no ill-formed sequence.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && string_valid |-> !invalid_seen && is_last)
    else $error("string_valid reported on an invalid or non-final item");

  // Final-only fields stay zero on other items.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> !string_valid && (safe_length == '0))
    else $error("final result fields set on a non-final item");

  // The input side only stalls when the input register holds an item.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid && out_valid)
    else $error("input stalled with an empty pipeline");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import utf8vt_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_WAIT      = 4;
  localparam int unsigned END_WAIT        = 10;

  // One result item as the block presents it.
  typedef struct packed {
    logic                 char_done;
    logic                 invalid_seen;
    logic                 is_last;
    logic                 string_valid;
    logic [LEN_WIDTH-1:0] safe_length;
  } verdict_t;

  // Tracks the decoder state of the current string and holds the verdicts
  // still owed by the block, oldest first.
  class utf8_verdict_board;
    logic [LEN_WIDTH-1:0]       limit;
    logic [COUNT_WIDTH_DEF-1:0] byte_count;
    logic [1:0]                 pending;
    cont_class_t                cls;
    logic                       err;
    logic [LEN_WIDTH-1:0]       prefix_end;
    verdict_t                   expected_q[$];
    int unsigned                mismatches;
    int unsigned                checked;

    function new();
      limit      = LIMIT_RESET;
      mismatches = 0;
      checked    = 0;
      clear_string();
    endfunction

    function void clear_string();
      byte_count = '0;
      pending    = '0;
      cls        = CLS_ANY;
      err        = 1'b0;
      prefix_end = '0;
    endfunction

    // Range test for the continuation byte that is due next.
    function bit cont_fits(logic [7:0] b);
      case (cls)
        CLS_A0_BF: return b >= CONT_HI_A0 && b <= CONT_MAX;
        CLS_80_9F: return b >= CONT_MIN && b <= CONT_LO_9F;
        CLS_90_BF: return b >= CONT_HI_90 && b <= CONT_MAX;
        CLS_80_8F: return b >= CONT_MIN && b <= CONT_LO_8F;
        default:   return (b & CONT_MASK) == CONT_TAG;
      endcase
    endfunction

    // Works out the verdict for one accepted byte and queues it.
    function void note_byte(logic [7:0] b, logic last);
      verdict_t v;
      logic     done;
      done = 1'b0;
      if (byte_count != '1) byte_count = byte_count + 1'b1;
      // Decoding stops at the first error until the string ends.
      if (!err) begin
        if (pending != 2'd0) begin
          if (cont_fits(b)) begin
            cls     = CLS_ANY;
            pending = pending - 2'd1;
            done    = (pending == 2'd0);
          end else begin
            err = 1'b1;
          end
        end else if (b <= ASCII_MAX) begin
          done = 1'b1;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          pending = 2'd1;
          cls     = CLS_ANY;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          pending = 2'd2;
          cls     = (b == LEAD3_MIN) ? CLS_A0_BF : (b == LEAD3_SURR) ? CLS_80_9F : CLS_ANY;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          pending = 2'd3;
          cls     = (b == LEAD4_MIN) ? CLS_90_BF : (b == LEAD4_MAX) ? CLS_80_8F : CLS_ANY;
        end else begin
          err = 1'b1;
        end
        if (done && byte_count <= limit) prefix_end = byte_count;
      end
      v.char_done    = done;
      v.invalid_seen = err;
      v.is_last      = last;
      v.string_valid = 1'b0;
      v.safe_length  = '0;
      // The final byte closes the string and clears the state.
      if (last) begin
        v.string_valid = !err && pending == 2'd0;
        v.safe_length  = (byte_count <= limit) ? byte_count : prefix_end;
        clear_string();
      end
      expected_q.insert(expected_q.size(), v);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compares one accepted result with the oldest expected verdict.
    task check_result(verdict_t got);
      verdict_t exp;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
      end else begin
        exp = expected_q.pop_front();
        if (got.char_done !== exp.char_done)
          report($sformatf("result %0d char_done %0b, expected %0b",
                           checked, got.char_done, exp.char_done));
        if (got.invalid_seen !== exp.invalid_seen)
          report($sformatf("result %0d invalid_seen %0b, expected %0b",
                           checked, got.invalid_seen, exp.invalid_seen));
        if (got.is_last !== exp.is_last)
          report($sformatf("result %0d is_last %0b, expected %0b",
                           checked, got.is_last, exp.is_last));
        if (got.string_valid !== exp.string_valid)
          report($sformatf("result %0d string_valid %0b, expected %0b",
                           checked, got.string_valid, exp.string_valid));
        if (got.safe_length !== exp.safe_length)
          report($sformatf("result %0d safe_length %0d, expected %0d",
                           checked, got.safe_length, exp.safe_length));
      end
    endtask

    function int unsigned expected_count();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           data_byte;
  logic                 last_byte;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LEN_WIDTH-1:0] limit_value;
  logic                 out_valid;
  logic                 out_stall;
  logic                 char_done;
  logic                 invalid_seen;
  logic                 is_last;
  logic                 string_valid;
  logic [LEN_WIDTH-1:0] safe_length;

  utf8_verdict_board board;
  logic [7:0]        str_q[$];
  bit                quiet_in;
  bit                quiet_out;
  bit                hold_off_req;
  bit                holding;
  int unsigned       cycle_count;

  utf8_validate_truncate_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .byte_limit   (limit_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_done    (char_done),
    .invalid_seen (invalid_seen),
    .is_last      (is_last),
    .string_valid (string_valid),
    .safe_length  (safe_length)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Idle and stall lengths: mostly short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Appends one byte to the string being built.
  function automatic void add_byte(logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endfunction

  // Number of continuation bytes that a lead byte asks for.
  function automatic int unsigned cont_total(logic [7:0] lead);
    if (lead >= LEAD4_MIN) return 3;
    if (lead >= LEAD3_MIN) return 2;
    return 1;
  endfunction

  function automatic logic [7:0] random_lead();
    case ($urandom_range(3, 0))
      0:       return 8'($urandom_range(LEAD2_MAX, LEAD2_MIN));
      1:       return 8'($urandom_range(LEAD3_MAX, LEAD3_MIN));
      2:       return 8'($urandom_range(LEAD4_MAX, LEAD4_MIN));
      default: begin
        case ($urandom_range(3, 0))
          0:       return LEAD3_MIN;
          1:       return LEAD3_SURR;
          2:       return LEAD4_MIN;
          default: return LEAD4_MAX;
        endcase
      end
    endcase
  endfunction

  // A well-formed second byte for the given lead.
  function automatic logic [7:0] second_byte(logic [7:0] lead);
    case (lead)
      LEAD3_MIN:  return 8'($urandom_range(CONT_MAX, CONT_HI_A0));
      LEAD3_SURR: return 8'($urandom_range(CONT_LO_9F, CONT_MIN));
      LEAD4_MIN:  return 8'($urandom_range(CONT_MAX, CONT_HI_90));
      LEAD4_MAX:  return 8'($urandom_range(CONT_LO_8F, CONT_MIN));
      default:    return 8'($urandom_range(CONT_MAX, CONT_MIN));
    endcase
  endfunction

  // Appends a lead byte followed by n correct continuation bytes.
  function automatic void push_seq(logic [7:0] lead, int unsigned n);
    add_byte(lead);
    for (int unsigned k = 0; k < n; k++)
      add_byte(k == 0 ? second_byte(lead) : 8'($urandom_range(CONT_MAX, CONT_MIN)));
  endfunction

  function automatic void push_good_char();
    logic [7:0] lead;
    if ($urandom_range(3, 0) == 0) begin
      add_byte(8'($urandom_range(ASCII_MAX, 0)));
    end else begin
      lead = random_lead();
      push_seq(lead, cont_total(lead));
    end
  endfunction

  // Ill-formed sequences of the usual kinds.
  function automatic void push_bad_seq();
    logic [7:0]  lead;
    int unsigned r;
    lead = random_lead();
    case ($urandom_range(4, 0))
      // Stray continuation byte.
      0: add_byte(8'($urandom_range(CONT_MAX, CONT_MIN)));
      // Overlong or out-of-range lead byte.
      1: begin
        r = $urandom_range(12, 0);
        add_byte(r < 2 ? 8'(8'hC0 + r) : 8'(8'hF5 + (r - 2)));
      end
      // Lead byte followed by a second byte outside its range.
      2: begin
        add_byte(lead);
        case (lead)
          LEAD3_MIN:  add_byte(8'($urandom_range(CONT_LO_9F, CONT_MIN)));
          LEAD3_SURR: add_byte(8'($urandom_range(CONT_MAX, CONT_HI_A0)));
          LEAD4_MIN:  add_byte(8'($urandom_range(CONT_LO_8F, CONT_MIN)));
          LEAD4_MAX:  add_byte(8'($urandom_range(CONT_MAX, CONT_HI_90)));
          default: begin
            if ($urandom_range(1, 0) == 0) add_byte(8'($urandom_range(ASCII_MAX, 0)));
            else add_byte(8'($urandom_range(8'hFF, 8'hC0)));
          end
        endcase
      end
      // Sequence cut short by a plain ASCII byte.
      3: begin
        push_seq(lead, $urandom_range(cont_total(lead) - 1, 0));
        add_byte(8'($urandom_range(ASCII_MAX, 0)));
      end
      default: add_byte(8'($urandom_range(8'hFF, 0)));
    endcase
  endfunction

  // Mostly well-formed strings, some with errors, some pure noise.
  function automatic void build_string();
    int unsigned nchars;
    logic [7:0]  lead;
    str_q.delete();
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(12, 1)) add_byte(8'($urandom_range(8'hFF, 0)));
    end else begin
      nchars = ($urandom_range(9, 0) < 8) ? $urandom_range(8, 1) : $urandom_range(30, 9);
      repeat (nchars) begin
        if ($urandom_range(11, 0) == 0) push_bad_seq();
        else push_good_char();
      end
      // Partial character left at the end of the string.
      if ($urandom_range(5, 0) == 0) begin
        lead = random_lead();
        push_seq(lead, $urandom_range(cont_total(lead) - 1, 0));
      end
    end
  endfunction

  task idle_input(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      in_valid  = 1'b0;
      data_byte = 8'($urandom);
      last_byte = 1'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offers one byte item and holds it until the block takes it.
  task send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    in_valid  = 1'b1;
    data_byte = b;
    last_byte = last;
    do @(posedge clk); while (in_stall);
    board.note_byte(b, last);
  endtask

  task send_string();
    for (int i = 0; i < str_q.size(); i++) begin
      if (!quiet_in) idle_input(gap_len());
      send_byte(str_q[i], i == str_q.size() - 1);
    end
  endtask

  task wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.expected_count() != 0) @(posedge clk);
  endtask

  // Limit writes happen only with the block empty.
  task write_limit(logic [LEN_WIDTH-1:0] v);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_valid   = 1'b1;
    limit_value = v;
    do @(posedge clk); while (!cfg_ready);
    board.limit = v;
    @(negedge clk);
    cfg_valid   = 1'b0;
    limit_value = LEN_WIDTH'($urandom);
  endtask

  task run_random(int unsigned target);
    int unsigned count;
    count = 0;
    while (count < target) begin
      build_string();
      count += str_q.size();
      if ($urandom_range(7, 0) == 0) quiet_in = !quiet_in;
      if ($urandom_range(7, 0) == 0) quiet_out = !quiet_out;
      send_string();
      if ($urandom_range(19, 0) == 0) wait_drained();
    end
  endtask

  // The receiver holds off while the sender keeps offering items.
  task run_pressure();
    int unsigned count;
    count    = 0;
    quiet_in = 1'b1;
    hold_off_req = 1'b1;
    wait (holding);
    while (count < 60) begin
      build_string();
      count += str_q.size();
      send_string();
    end
    quiet_in = 1'b0;
  endtask

  task run_directed();
    // Extremes of the single-byte range and the two-byte leads.
    str_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF};
    send_string();
    // Three-byte boundaries after E0 and ED.
    str_q = '{8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF};
    send_string();
    // Four-byte boundaries after F0 and F4.
    str_q = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    // Stray continuation byte.
    str_q = '{8'h80};
    send_string();
    // Second byte out of range after E0.
    str_q = '{8'hE0, 8'h9F};
    send_string();
    // Invalid lead bytes.
    str_q = '{8'hC1};
    send_string();
    str_q = '{8'hFF};
    send_string();
    // Partial character at the end of the string.
    str_q = '{8'hE2, 8'h82};
    send_string();
  endtask

  // Receiver: random stalls, quiet stretches and one long hold-off.
  initial begin
    int unsigned run;
    out_stall = 1'b0;
    holding   = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        holding      = 1'b1;
        out_stall    = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding = 1'b0;
      end else if (quiet_out) begin
        out_stall = 1'b0;
        @(negedge clk);
      end else begin
        out_stall = ($urandom_range(99, 0) < 35);
        run = out_stall ? gap_len() + 1 : $urandom_range(8, 1);
        repeat (run) @(negedge clk);
      end
    end
  end

  // Result checking at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(verdict_t'{char_done, invalid_seen, is_last, string_valid,
                                    safe_length});
  end

  // Main sequence.
  initial begin
    board        = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    data_byte    = '0;
    last_byte    = 1'b0;
    cfg_valid    = 1'b0;
    limit_value  = '0;
    quiet_in     = 1'b0;
    quiet_out    = 1'b0;
    hold_off_req = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    write_limit('0);
    run_random(100);
    write_limit('1);
    run_random(100);
    write_limit(16'd1);
    run_pressure();
    run_random(100);
    repeat (6) begin
      write_limit(LEN_WIDTH'($urandom_range(40, 2)));
      run_random(100);
    end
    write_limit(LEN_WIDTH'($urandom_range(65535, 0)));
    run_random(100);

    wait_drained();
    repeat (END_WAIT) @(posedge clk);
    if (board.mismatches == 0 && board.expected_count() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* utf8_validate_truncate_unit.f */
src/utf8vt_pkg.sv
src/utf8vt_decode.sv
src/utf8_validate_truncate_unit.sv
tb/tb_top.sv
